// ===== rtl/qldt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qldt_pkg
// Shared types and constants for the qualified level/delta trigger.
// ----------------------------------------------------------------------------
package qldt_pkg;

   localparam int QLDT_SAMPLE_WIDTH = 16;
   localparam int LIMIT_WIDTH       = 16;
   localparam int COND_WIDTH        = 5;
   localparam int NUM_REGS          = 6;
   localparam int CSR_INDEX_WIDTH   = $clog2(NUM_REGS);
   localparam int CSR_DATA_WIDTH    = LIMIT_WIDTH;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ENABLE_MASK = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HIGH_LEVEL  = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LOW_LEVEL   = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DELTA_LIMIT = CSR_INDEX_WIDTH'(3);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RISE_LIMIT  = CSR_INDEX_WIDTH'(4);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FALL_LIMIT  = CSR_INDEX_WIDTH'(5);

   // condition bit positions
   localparam int COND_UPPER = 0;
   localparam int COND_LOWER = 1;
   localparam int COND_DELTA = 2;
   localparam int COND_FALL  = 3;
   localparam int COND_RISE  = 4;

   localparam logic [COND_WIDTH-1:0] LEVEL_SET  = 5'b00011;
   localparam logic [COND_WIDTH-1:0] CHANGE_SET = 5'b11100;

   // reset values
   localparam logic [COND_WIDTH-1:0]  ENABLE_MASK_RESET = 5'd3;
   localparam logic [LIMIT_WIDTH-1:0] HIGH_LEVEL_RESET  = 16'd0;
   localparam logic [LIMIT_WIDTH-1:0] LOW_LEVEL_RESET   = 16'd1;
   localparam logic [LIMIT_WIDTH-1:0] DELTA_LIMIT_RESET = 16'd0;
   localparam logic [LIMIT_WIDTH-1:0] RISE_LIMIT_RESET  = 16'd0;
   localparam logic [LIMIT_WIDTH-1:0] FALL_LIMIT_RESET  = 16'd0;

   typedef struct packed {
      logic [COND_WIDTH-1:0]  enable_mask;
      logic [LIMIT_WIDTH-1:0] high_level;
      logic [LIMIT_WIDTH-1:0] low_level;
      logic [LIMIT_WIDTH-1:0] delta_limit;
      logic [LIMIT_WIDTH-1:0] rise_limit;
      logic [LIMIT_WIDTH-1:0] fall_limit;
   } cfg_type;

   typedef struct packed {
      logic                  fire;
      logic [COND_WIDTH-1:0] met;
   } verdict_type;

endpackage : qldt_pkg
`default_nettype wire

// ===== rtl/qldt_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qldt_if
// Valid/ready channels for sample words and trigger result words.
// ----------------------------------------------------------------------------
interface qldt_req_if
   import qldt_pkg::*;
#(
   parameter int SAMPLE_WIDTH = QLDT_SAMPLE_WIDTH
);
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] sample;
   logic                    forget_limits;

   modport source (output valid, output sample, output forget_limits, input ready);
   modport sink   (input valid, input sample, input forget_limits, output ready);
endinterface : qldt_req_if

interface qldt_rsp_if
   import qldt_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic                  fired;
   logic [COND_WIDTH-1:0] conditions;

   modport source (output valid, output fired, output conditions, input ready);
   modport sink   (input valid, input fired, input conditions, output ready);
endinterface : qldt_rsp_if
`default_nettype wire

// ===== rtl/qldt_judge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qldt_judge
// Level and delta condition tests for one sample, plus the fire decision.
// ----------------------------------------------------------------------------
module qldt_judge
   import qldt_pkg::*;
#(
   parameter int SAMPLE_WIDTH = QLDT_SAMPLE_WIDTH
) (
   input  wire logic [SAMPLE_WIDTH-1:0] sample,
   input  wire logic                    forget_limits,
   input  wire logic [SAMPLE_WIDTH-1:0] reference_value,
   input  wire logic [COND_WIDTH-1:0]   last_fired_set,
   input  wire cfg_type                 cfg,
   output verdict_type                  verdict
);

   localparam int CMP_W = (SAMPLE_WIDTH > LIMIT_WIDTH) ? SAMPLE_WIDTH : LIMIT_WIDTH;

   logic                    rising;
   logic                    falling;
   logic [SAMPLE_WIDTH-1:0] change;
   logic [CMP_W-1:0]        sample_x;
   logic [CMP_W-1:0]        change_x;
   logic                    over_delta;
   logic [COND_WIDTH-1:0]   met;
   logic [COND_WIDTH-1:0]   prior_set;

   assign rising   = sample > reference_value;
   assign falling  = sample < reference_value;
   assign change   = rising ? (sample - reference_value) : (reference_value - sample);
   assign sample_x = CMP_W'(sample);
   assign change_x = CMP_W'(change);
   assign over_delta = change_x > CMP_W'(cfg.delta_limit);

   always_comb begin
      met = '0;
      met[COND_UPPER] = cfg.enable_mask[COND_UPPER] && (sample_x > CMP_W'(cfg.high_level));
      met[COND_LOWER] = cfg.enable_mask[COND_LOWER] && (sample_x <= CMP_W'(cfg.low_level));
      met[COND_DELTA] = cfg.enable_mask[COND_DELTA] && (rising || falling) && over_delta;
      met[COND_RISE]  = cfg.enable_mask[COND_RISE] && rising
                        && (change_x > CMP_W'(cfg.rise_limit));
      met[COND_FALL]  = cfg.enable_mask[COND_FALL] && falling
                        && (change_x > CMP_W'(cfg.fall_limit));
   end

   // a clear request drops the remembered set before the test
   assign prior_set = forget_limits ? '0 : last_fired_set;

   assign verdict.met  = met;
   assign verdict.fire = ((met & CHANGE_SET) != '0) || ((met & ~prior_set & LEVEL_SET) != '0);

endmodule : qldt_judge
`default_nettype wire

// ===== rtl/qualified_level_delta_trigger.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qualified_level_delta_trigger
// Judges each sample word against level and delta limits and fires when a
// change condition holds or a level condition appears that was not last fired.
// ----------------------------------------------------------------------------
// path: each sample is held in the input register, then its verdict in the
// result register, entered only when that register is empty or drained
// throughput: one sample per cycle while results are taken, set by the judge
// between them; reference and fired-set feedback updates as a sample advances
// reset: synchronous, active high; clears both stages, the reference, the
// fired set, and loads the register reset values
module qualified_level_delta_trigger
   import qldt_pkg::*;
#(
   parameter int SAMPLE_WIDTH = QLDT_SAMPLE_WIDTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   qldt_req_if.sink                        req_ch,
   qldt_rsp_if.source                      rsp_ch,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   cfg_type                 cfg_ff;
   logic                    s1_valid_ff;
   logic [SAMPLE_WIDTH-1:0] s1_sample_ff;
   logic                    s1_forget_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_fired_ff;
   logic [COND_WIDTH-1:0]   rsp_conditions_ff;
   logic [SAMPLE_WIDTH-1:0] reference_ff;
   logic [SAMPLE_WIDTH-1:0] reference_in;
   logic [COND_WIDTH-1:0]   last_set_ff;
   logic [COND_WIDTH-1:0]   last_set_in;
   verdict_type             verdict;
   logic                    req_take;
   logic                    advance;

   qldt_judge #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_judge (
      .sample          (s1_sample_ff),
      .forget_limits   (s1_forget_ff),
      .reference_value (reference_ff),
      .last_fired_set  (last_set_ff),
      .cfg             (cfg_ff),
      .verdict         (verdict)
   );

   // stage 1 moves on when the result register is empty or being drained
   assign advance  = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_take = req_ch.valid && req_ch.ready;

   always_comb begin
      reference_in = reference_ff;
      last_set_in  = last_set_ff;
      if (advance) begin
         if (verdict.fire) begin
            reference_in = s1_sample_ff;
            last_set_in  = verdict.met;
         end else if (s1_forget_ff) begin
            last_set_in  = '0;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_mask <= ENABLE_MASK_RESET;
         cfg_ff.high_level  <= HIGH_LEVEL_RESET;
         cfg_ff.low_level   <= LOW_LEVEL_RESET;
         cfg_ff.delta_limit <= DELTA_LIMIT_RESET;
         cfg_ff.rise_limit  <= RISE_LIMIT_RESET;
         cfg_ff.fall_limit  <= FALL_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_ENABLE_MASK: begin
               cfg_ff.enable_mask <= csr_write_data[COND_WIDTH-1:0];
            end
            REG_HIGH_LEVEL: begin
               cfg_ff.high_level <= csr_write_data;
            end
            REG_LOW_LEVEL: begin
               cfg_ff.low_level <= csr_write_data;
            end
            REG_DELTA_LIMIT: begin
               cfg_ff.delta_limit <= csr_write_data;
            end
            REG_RISE_LIMIT: begin
               cfg_ff.rise_limit <= csr_write_data;
            end
            REG_FALL_LIMIT: begin
               cfg_ff.fall_limit <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   // control and trigger state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         reference_ff <= '0;
         last_set_ff  <= '0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         reference_ff <= reference_in;
         last_set_ff  <= last_set_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sample_ff <= req_ch.sample;
         s1_forget_ff <= req_ch.forget_limits;
      end
      if (advance) begin
         rsp_fired_ff      <= verdict.fire;
         rsp_conditions_ff <= verdict.met;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.fired      = rsp_fired_ff;
   assign rsp_ch.conditions = rsp_conditions_ff;

endmodule : qualified_level_delta_trigger
`default_nettype wire

// ===== tb/qualified_level_delta_trigger_tb.sv =====
// ----------------------------------------------------------------------------
// qualified_level_delta_trigger_tb
// Self-checking bench for the level/delta sample trigger. Sample words go in
// through a randomly paced valid/ready driver and result words are taken by a
// randomly stalling monitor. Each result word is compared with a verdict
// predicted when its sample word was accepted. The limit registers are
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module qualified_level_delta_trigger_tb;
   import qldt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int RANDOM_PHASES   = 9;
   localparam int WORDS_PER_PHASE = 160;
   localparam int HOLD_CYCLES     = 300;
   localparam int MAX_PAUSE       = 18;
   localparam int REPORT_LIMIT    = 10;

   // indexes that decode to no register
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNMAPPED_LO = CSR_INDEX_WIDTH'(6);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNMAPPED_HI = CSR_INDEX_WIDTH'(7);

   localparam logic [QLDT_SAMPLE_WIDTH-1:0] SAMPLE_MAX = '1;

   typedef enum int {PACE_FULL, PACE_BURSTY, PACE_SLOW} pace_type;

   typedef struct packed {
      logic [QLDT_SAMPLE_WIDTH-1:0] sample;
      logic                         forget;
   } sample_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   qldt_req_if #(.SAMPLE_WIDTH(QLDT_SAMPLE_WIDTH)) req_if ();
   qldt_rsp_if rsp_if ();

   qualified_level_delta_trigger #(
      .SAMPLE_WIDTH(QLDT_SAMPLE_WIDTH)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_if),
      .rsp_ch           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   cfg_type                      model_cfg;
   logic [QLDT_SAMPLE_WIDTH-1:0] reference_word;
   logic [COND_WIDTH-1:0]        fired_set;

   sample_word_type word_queue[$];
   verdict_type     verdict_q[$];
   sample_word_type next_word;
   verdict_type     want;

   pace_type send_pace = PACE_FULL;
   pace_type take_pace = PACE_FULL;
   int send_pause;
   int take_pause;
   int hold_count;
   logic hold_request;
   logic hold_started;
   logic hold_off;
   int error_count = 0;
   int result_count = 0;
   int cycle_count = 0;

   function automatic int draw_pause(input pace_type pace);
      case (pace)
         PACE_FULL:   return 0;
         PACE_BURSTY: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_PAUSE) : 0;
         default:     return $urandom_range(0, MAX_PAUSE);
      endcase
   endfunction

   function automatic verdict_type predict_verdict(
      input logic [QLDT_SAMPLE_WIDTH-1:0] value,
      input logic                         forget
   );
      verdict_type v;
      logic [QLDT_SAMPLE_WIDTH-1:0] diff;
      if (forget)
         fired_set = '0;
      v.met = '0;
      if (model_cfg.enable_mask[COND_UPPER] && value > model_cfg.high_level)
         v.met[COND_UPPER] = 1'b1;
      if (model_cfg.enable_mask[COND_LOWER] && value <= model_cfg.low_level)
         v.met[COND_LOWER] = 1'b1;
      if (value > reference_word) begin
         diff = value - reference_word;
         if (model_cfg.enable_mask[COND_DELTA] && diff > model_cfg.delta_limit)
            v.met[COND_DELTA] = 1'b1;
         if (model_cfg.enable_mask[COND_RISE] && diff > model_cfg.rise_limit)
            v.met[COND_RISE] = 1'b1;
      end else if (value < reference_word) begin
         diff = reference_word - value;
         if (model_cfg.enable_mask[COND_DELTA] && diff > model_cfg.delta_limit)
            v.met[COND_DELTA] = 1'b1;
         if (model_cfg.enable_mask[COND_FALL] && diff > model_cfg.fall_limit)
            v.met[COND_FALL] = 1'b1;
      end
      // a level condition only counts when it is new against the last fired set
      v.fire = ((v.met & CHANGE_SET) != '0) || ((v.met & ~fired_set & LEVEL_SET) != '0);
      if (v.fire) begin
         reference_word = value;
         fired_set = v.met;
      end
      return v;
   endfunction

   // sample word driver; verdicts are predicted at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.sample <= '0;
         req_if.forget_limits <= 1'b0;
         send_pause = 0;
         reference_word = '0;
         fired_set = '0;
      end else begin
         if (req_if.valid && req_if.ready)
            verdict_q.push_back(predict_verdict(req_if.sample, req_if.forget_limits));
         if (!req_if.valid || req_if.ready) begin
            if (send_pause > 0) begin
               send_pause--;
               req_if.valid <= 1'b0;
            end else if (word_queue.size() > 0) begin
               next_word = word_queue.pop_front();
               req_if.sample <= next_word.sample;
               req_if.forget_limits <= next_word.forget;
               req_if.valid <= 1'b1;
               send_pause = draw_pause(send_pace);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_started <= 1'b0;
         hold_count <= 0;
         hold_off <= 1'b0;
      end else begin
         if (hold_request && !hold_started) begin
            hold_started <= 1'b1;
            hold_count <= HOLD_CYCLES;
         end else if (hold_count > 0) begin
            hold_count <= hold_count - 1;
         end
         hold_off <= (hold_count > 0);
      end
   end

   // result word monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         take_pause = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            result_count++;
            if (verdict_q.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("result word %0d unexpected: fired=%0b conditions=%b",
                           result_count, rsp_if.fired, rsp_if.conditions);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_if.fired !== want.fire || rsp_if.conditions !== want.met) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display("result word %0d: expected fired=%0b cond=%b, got %0b %b",
                              result_count, want.fire, want.met,
                              rsp_if.fired, rsp_if.conditions);
               end
            end
            take_pause = draw_pause(take_pace);
         end else if (take_pause > 0) begin
            take_pause--;
         end
         rsp_if.ready <= (take_pause == 0) && !hold_off;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("qualified_level_delta_trigger_tb: errors");
         $finish;
      end
   end

   task automatic write_register(
      input logic [CSR_INDEX_WIDTH-1:0] index,
      input logic [CSR_DATA_WIDTH-1:0]  data
   );
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      case (index)
         REG_ENABLE_MASK: model_cfg.enable_mask = data[COND_WIDTH-1:0];
         REG_HIGH_LEVEL:  model_cfg.high_level = data;
         REG_LOW_LEVEL:   model_cfg.low_level = data;
         REG_DELTA_LIMIT: model_cfg.delta_limit = data;
         REG_RISE_LIMIT:  model_cfg.rise_limit = data;
         REG_FALL_LIMIT:  model_cfg.fall_limit = data;
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(
      input logic [CSR_DATA_WIDTH-1:0] mask_word,
      input logic [CSR_DATA_WIDTH-1:0] upper,
      input logic [CSR_DATA_WIDTH-1:0] lower,
      input logic [CSR_DATA_WIDTH-1:0] delta,
      input logic [CSR_DATA_WIDTH-1:0] rise,
      input logic [CSR_DATA_WIDTH-1:0] fall
   );
      write_register(REG_ENABLE_MASK, mask_word);
      write_register(REG_HIGH_LEVEL, upper);
      write_register(REG_LOW_LEVEL, lower);
      write_register(REG_DELTA_LIMIT, delta);
      write_register(REG_RISE_LIMIT, rise);
      write_register(REG_FALL_LIMIT, fall);
      @(negedge clock);
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      while (word_queue.size() != 0 || req_if.valid || verdict_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic push_word(input logic [QLDT_SAMPLE_WIDTH-1:0] value, input logic forget);
      sample_word_type w;
      w.sample = value;
      w.forget = forget;
      word_queue.push_back(w);
   endtask

   function automatic logic [CSR_DATA_WIDTH-1:0] pick_limit();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return CSR_DATA_WIDTH'($urandom_range(0, 65535));
         default: return CSR_DATA_WIDTH'($urandom_range(0, 2000));
      endcase
   endfunction

   // samples cluster around the previous one and the limits so that
   // the comparisons land on both sides of each threshold
   function automatic logic [QLDT_SAMPLE_WIDTH-1:0] pick_sample(
      input logic [QLDT_SAMPLE_WIDTH-1:0] prev
   );
      int v;
      int span;
      case ($urandom_range(0, 11))
         0: v = 0;
         1: v = int'(SAMPLE_MAX);
         2, 3: v = $urandom_range(0, 65535);
         4: v = int'(prev);
         5: v = int'(model_cfg.high_level) + $urandom_range(0, 2) - 1;
         6: v = int'(model_cfg.low_level) + $urandom_range(0, 2) - 1;
         7: v = int'(reference_word) + $urandom_range(0, 2) - 1;
         default: begin
            case ($urandom_range(0, 2))
               0:       span = int'(model_cfg.delta_limit);
               1:       span = int'(model_cfg.rise_limit);
               default: span = int'(model_cfg.fall_limit);
            endcase
            if (span > 4000)
               span = $urandom_range(0, 4000);
            span = span + 2;
            v = int'(prev) + $urandom_range(0, 2 * span) - span;
         end
      endcase
      if (v < 0)
         v = 0;
      if (v > int'(SAMPLE_MAX))
         v = int'(SAMPLE_MAX);
      return QLDT_SAMPLE_WIDTH'(v);
   endfunction

   initial begin
      logic [QLDT_SAMPLE_WIDTH-1:0] walk;
      hold_request = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      model_cfg.enable_mask = ENABLE_MASK_RESET;
      model_cfg.high_level = HIGH_LEVEL_RESET;
      model_cfg.low_level = LOW_LEVEL_RESET;
      model_cfg.delta_limit = DELTA_LIMIT_RESET;
      model_cfg.rise_limit = RISE_LIMIT_RESET;
      model_cfg.fall_limit = FALL_LIMIT_RESET;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset limits: level conditions fire only when new
      push_word(16'd0, 1'b0);
      push_word(16'd0, 1'b0);
      push_word(16'd1, 1'b0);
      push_word(16'd2, 1'b0);
      push_word(SAMPLE_MAX, 1'b0);
      push_word(SAMPLE_MAX, 1'b1);
      push_word(16'd0, 1'b0);
      wait_quiet();

      // everything enabled, junk in the unused mask bits
      configure(16'hFFE0 | 16'h001F, 16'd40000, 16'd1000, 16'd500, 16'd300, 16'd200);
      push_word(16'd0, 1'b0);
      push_word(16'd0, 1'b1);
      push_word(16'd600, 1'b0);
      push_word(16'd600, 1'b0);
      push_word(16'd900, 1'b0);
      push_word(16'd1201, 1'b0);
      push_word(SAMPLE_MAX, 1'b0);
      push_word(16'd0, 1'b0);
      push_word(16'd32768, 1'b0);
      wait_quiet();

      // nothing enabled
      configure(16'hAAA0, 16'd0, SAMPLE_MAX, 16'd0, 16'd0, 16'd0);
      push_word(16'd0, 1'b0);
      push_word(SAMPLE_MAX, 1'b1);
      push_word(16'h5555, 1'b0);
      wait_quiet();

      // unmapped writes change nothing, then extreme limits
      write_register(REG_UNMAPPED_LO, 16'hFFFF);
      write_register(REG_UNMAPPED_HI, 16'h5A5A);
      push_word(16'd0, 1'b0);
      wait_quiet();
      configure(16'h001F, SAMPLE_MAX, 16'd0, SAMPLE_MAX, 16'd0, 16'hFFFE);
      push_word(16'd0, 1'b0);
      push_word(SAMPLE_MAX, 1'b0);
      push_word(16'd1, 1'b0);
      push_word(16'd0, 1'b1);
      push_word(16'd0, 1'b0);
      wait_quiet();

      walk = 16'd0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         // random enables with junk above the mask bits
         configure(CSR_DATA_WIDTH'($urandom_range(0, 65535)),
                   pick_limit(), pick_limit(), pick_limit(), pick_limit(), pick_limit());
         if (phase == 0) begin
            send_pace = PACE_FULL;
            take_pace = PACE_BURSTY;
         end else begin
            send_pace = pace_type'($urandom_range(0, 2));
            take_pace = pace_type'($urandom_range(0, 2));
         end
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            walk = pick_sample(walk);
            push_word(walk, $urandom_range(0, 7) == 0);
         end
         // receiver stops while the sender keeps offering words
         if (phase == 0)
            hold_request = 1'b1;
         wait_quiet();
      end

      repeat (8) @(negedge clock);
      if (error_count == 0)
         $display("qualified_level_delta_trigger_tb: clean");
      else
         $display("qualified_level_delta_trigger_tb: errors");
      $finish;
   end

endmodule : qualified_level_delta_trigger_tb

// ===== files.f =====
rtl/qldt_pkg.sv
rtl/qldt_if.sv
rtl/qldt_judge.sv
rtl/qualified_level_delta_trigger.sv
tb/qualified_level_delta_trigger_tb.sv
